FILE: rtl/core/psdc_pkg.sv
// ----------------------------------------------------------------------------
// psdc_pkg
// Shared types, widths and the pulse-shape coefficient ROM of the deconvolver.
// ----------------------------------------------------------------------------
package psdc_pkg;

  localparam int WAVE_LENGTH  = 64;
  localparam int IDX_W        = $clog2(WAVE_LENGTH);
  localparam int SHAPE_OFFSET = 8;

  localparam int SAMPLE_W = 12;
  localparam int PED_W    = 16;
  localparam int DATA_W   = 32;
  localparam int COEF_W   = 16;
  localparam int OUT_IDX_W = 6;
  localparam int ADDR_W   = 3;

  localparam int DIFF_W   = 22;
  localparam int PROD_W   = COEF_W + 1 + DATA_W;
  localparam int ACC_W    = 47 + IDX_W;
  localparam int CLAMP_W  = 47;
  localparam int ESC_W    = 19;
  localparam int SCALED_W = CLAMP_W + ESC_W;
  localparam int ROUND_SH = 31;
  localparam int YW_W     = SCALED_W - ROUND_SH;

  localparam logic signed [ESC_W-1:0]   E_Q16     = ESC_W'(178145);
  localparam logic signed [ACC_W-1:0]   ACC_LIMIT = ACC_W'(64'sd1 <<< 45);
  localparam logic [63:0]               EXP_STEP_Q31 = 64'd1895147668;

  // register word index (paddr[2])
  localparam logic REG_PEDESTAL = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_SCALE,
    ST_WRITE
  } psdc_state_t;

  typedef struct packed {
    logic load;
    logic tap_valid;
  } mac_ctrl_t;

  typedef logic [COEF_W-1:0] shape_rom_t [WAVE_LENGTH];

  // h(d+8) in q1.15 from a running exp(-k/8) in q31
  function automatic shape_rom_t build_shape_rom();
    shape_rom_t rom;
    logic [63:0] ex;
    logic [63:0] term;
    rom = '{default: '0};
    ex  = 64'h8000_0000;
    for (int k = 0; k < SHAPE_OFFSET + WAVE_LENGTH; k++) begin
      if (k >= SHAPE_OFFSET) begin
        term = 64'(k) * ex + 64'h4_0000;
        rom[k - SHAPE_OFFSET] = term[34:19];
      end
      ex = (ex * EXP_STEP_Q31 + 64'h4000_0000) >> 31;
    end
    return rom;
  endfunction

  localparam shape_rom_t SHAPE_ROM = build_shape_rom();

endpackage

FILE: rtl/core/psdc_cell.sv
// ----------------------------------------------------------------------------
// psdc_cell
// One slot of the result ring: holds one earlier result and passes it on.
// ----------------------------------------------------------------------------
module psdc_cell import psdc_pkg::*; (
  input  logic                     clk,
  input  logic                     shift_en,
  input  logic                     load_en,
  input  logic signed [DATA_W-1:0] load_data,
  input  logic signed [DATA_W-1:0] data_in,
  output logic signed [DATA_W-1:0] data_out
);

  logic signed [DATA_W-1:0] value;

  always_ff @(posedge clk) begin
    if (load_en) begin
      value <= load_data;
    end else if (shift_en) begin
      value <= data_in;
    end
  end

  assign data_out = value;

endmodule

FILE: rtl/core/psdc_mac.sv
// ----------------------------------------------------------------------------
// psdc_mac
// Shared multiply-subtract unit: one coefficient times one earlier result
// per cycle, registered product, wide accumulator.
// ----------------------------------------------------------------------------
module psdc_mac import psdc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  mac_ctrl_t                ctrl,
  input  logic signed [ACC_W-1:0]  init_value,
  input  logic [COEF_W-1:0]        coef,
  input  logic signed [DATA_W-1:0] head,
  output logic signed [ACC_W-1:0]  acc
);

  logic                     prod_valid;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_next;
  logic signed [ACC_W-1:0]  acc_reg;

  assign prod_next = $signed({1'b0, coef}) * head;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (ctrl.load) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctrl.tap_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod <= prod_next;
    if (ctrl.load) begin
      acc_reg <= init_value;
    end else if (prod_valid) begin
      acc_reg <= acc_reg - ACC_W'(prod);
    end
  end

  assign acc = acc_reg;

endmodule

FILE: rtl/core/psdc_scale.sv
// ----------------------------------------------------------------------------
// psdc_scale
// Clamp, multiply by e in q16, round half up to q24.8 and saturate.
// ----------------------------------------------------------------------------
module psdc_scale import psdc_pkg::*; (
  input  logic                     clk,
  input  logic                     load,
  input  logic signed [ACC_W-1:0]  acc,
  output logic signed [DATA_W-1:0] y,
  output logic                     sat
);

  logic signed [ACC_W-1:0]    acc_clip;
  logic signed [CLAMP_W-1:0]  clamped;
  logic signed [SCALED_W-1:0] scaled;
  logic signed [SCALED_W-1:0] rounded;
  logic signed [YW_W-1:0]     y_wide;

  localparam logic signed [YW_W-1:0] Y_MAX = YW_W'(64'sd2147483647);
  localparam logic signed [YW_W-1:0] Y_MIN = -(YW_W'(64'sd2147483648));

  always_comb begin
    if (acc > ACC_LIMIT) begin
      acc_clip = ACC_LIMIT;
    end else if (acc < -ACC_LIMIT) begin
      acc_clip = -ACC_LIMIT;
    end else begin
      acc_clip = acc;
    end
  end

  assign clamped = acc_clip[CLAMP_W-1:0];

  always_ff @(posedge clk) begin
    if (load) begin
      scaled <= clamped * E_Q16;
    end
  end

  assign rounded = scaled + (SCALED_W'(1) <<< (ROUND_SH - 1));
  assign y_wide  = rounded[SCALED_W-1:ROUND_SH];

  always_comb begin
    if (y_wide > Y_MAX) begin
      y   = Y_MAX[DATA_W-1:0];
      sat = 1'b1;
    end else if (y_wide < Y_MIN) begin
      y   = Y_MIN[DATA_W-1:0];
      sat = 1'b1;
    end else begin
      y   = y_wide[DATA_W-1:0];
      sat = 1'b0;
    end
  end

endmodule

FILE: rtl/core/pulse_shape_deconvolver_core.sv
// ----------------------------------------------------------------------------
// pulse_shape_deconvolver_core
// Forward-substitution deconvolution of adc waveforms against a fixed pulse
// shape, using a rotating ring of result cells and one shared mac unit.
// ----------------------------------------------------------------------------
// an accepted request takes one full revolution of the result ring
//   through the single multiply-subtract unit, then drain, scale and write;
//   new requests stall until the state machine is back in idle
// reset: synchronous; clears state machine, position, pedestal and out_valid;
//   the result ring is not cleared and needs no clearing pass
// ----------------------------------------------------------------------------
module pulse_shape_deconvolver_core import psdc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [SAMPLE_W-1:0]      sample_value,
  input  logic                     first_sample,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] deconvolved_value,
  output logic [OUT_IDX_W-1:0]     sample_index,
  output logic                     saturated
);

  psdc_state_t state, state_next;

  logic [PED_W-1:0]        pedestal;
  logic [IDX_W-1:0]        position;
  logic [IDX_W-1:0]        cur_index;
  logic [IDX_W-1:0]        new_index;
  logic [IDX_W-1:0]        step;
  logic                    accept;
  logic                    out_free;
  logic                    ring_shift;
  logic                    ring_load;
  logic                    scale_load;
  logic                    last_step;
  mac_ctrl_t               mac_ctrl;
  logic signed [DIFF_W-1:0] diff;
  logic signed [ACC_W-1:0] start_acc;
  logic signed [ACC_W-1:0] acc;
  logic [IDX_W-1:0]        coef_addr;
  logic [COEF_W-1:0]       coef;
  logic signed [DATA_W-1:0] y_value;
  logic                    y_sat;
  logic [IDX_W+OUT_IDX_W-1:0] index_ext;
  logic signed [DATA_W-1:0] ring [WAVE_LENGTH];

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PEDESTAL) ? {{(32-PED_W){1'b0}}, pedestal} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pedestal <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_PEDESTAL)) begin
      pedestal <= pwdata[PED_W-1:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign last_step = (step == IDX_W'(WAVE_LENGTH - 1));
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_RUN;
      ST_RUN:   if (last_step) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_SCALE;
      ST_SCALE: state_next = ST_WRITE;
      ST_WRITE: if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall           = 1'b1;
    ring_shift         = 1'b0;
    ring_load          = 1'b0;
    scale_load         = 1'b0;
    mac_ctrl.load      = 1'b0;
    mac_ctrl.tap_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall      = rst;
        mac_ctrl.load = in_valid;
      end
      ST_RUN: begin
        ring_shift         = 1'b1;
        mac_ctrl.tap_valid = (step < cur_index);
      end
      ST_DRAIN: begin
      end
      ST_SCALE: begin
        scale_load = 1'b1;
      end
      ST_WRITE: begin
        ring_load = out_free;
      end
      default: begin
      end
    endcase
  end

  assign accept    = in_valid && !in_stall;
  assign new_index = first_sample ? '0 : position;

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      step     <= '0;
    end else begin
      if (accept) begin
        position <= (new_index == IDX_W'(WAVE_LENGTH - 1)) ? '0 : new_index + 1'b1;
      end
      if (state == ST_RUN) begin
        step <= last_step ? '0 : step + 1'b1;
      end else begin
        step <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_index <= new_index;
    end
  end

  // pedestal-subtracted sample in q.23
  assign diff = $signed({2'b00, sample_value, 8'h00}) - $signed({2'b00, pedestal, 4'h0});
  assign start_acc = ACC_W'(diff) <<< 15;

  // result ring
  for (genvar k = 0; k < WAVE_LENGTH; k++) begin : g_ring
    psdc_cell u_cell (
      .clk       (clk),
      .shift_en  (ring_shift),
      .load_en   (ring_load && (cur_index == IDX_W'(k))),
      .load_data (y_value),
      .data_in   (ring[(k + 1) % WAVE_LENGTH]),
      .data_out  (ring[k])
    );
  end

  assign coef_addr = cur_index - step;
  assign coef      = SHAPE_ROM[coef_addr];

  psdc_mac u_mac (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (mac_ctrl),
    .init_value (start_acc),
    .coef       (coef),
    .head       (ring[0]),
    .acc        (acc)
  );

  psdc_scale u_scale (
    .clk  (clk),
    .load (scale_load),
    .acc  (acc),
    .y    (y_value),
    .sat  (y_sat)
  );

  // output register
  assign index_ext = {{OUT_IDX_W{1'b0}}, cur_index};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ring_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ring_load) begin
      deconvolved_value <= y_value;
      sample_index      <= index_ext[OUT_IDX_W-1:0];
      saturated         <= y_sat;
    end
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for pulse_shape_deconvolver_core. Samples go in over a
// valid/stall channel, results come back over another, both with random
// idling. A bit-exact deconvolution predictor scores most results in order.
// The pedestal register is reprogrammed between phases over the apb port.
// ----------------------------------------------------------------------------
module tb import psdc_pkg::*;;

  localparam int                HOLD_CYCLES   = 600;
  localparam int                LATENCY       = WAVE_LENGTH + 4;
  localparam int                RAND_PHASES   = 8;
  localparam int                PHASE_ITEMS   = 172;
  localparam int                SHAPE_OFS     = 8;
  localparam logic [ADDR_W-1:0] ADDR_PEDESTAL = ADDR_W'({REG_PEDESTAL, 2'b00});
  localparam logic [ADDR_W-1:0] ADDR_SPARE    = ADDR_W'(4);
  localparam longint            E_SCALE       = 64'sd178145;
  localparam longint            ACC_BOUND     = 64'sd1 <<< 45;
  localparam longint            Y_MAX         = 64'sd2147483647;
  localparam longint            Y_MIN         = -64'sd2147483648;

  typedef struct packed {
    logic [DATA_W-1:0]    amp;
    logic [OUT_IDX_W-1:0] idx;
    logic                 sat;
  } decon_result_t;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    logic [ADDR_W-1:0]   addr;
    logic [31:0]         wdata;
    logic [SAMPLE_W-1:0] smp;
    logic                first;
    logic                typed;
    decon_result_t       want;
  } stim_row_t;

  logic                     clk          = 1'b0;
  logic                     rst          = 1'b1;
  logic                     psel         = 1'b0;
  logic                     penable      = 1'b0;
  logic                     pwrite       = 1'b0;
  logic [ADDR_W-1:0]        paddr        = '0;
  logic [31:0]              pwdata       = '0;
  logic [31:0]              prdata;
  logic                     pready;
  logic                     in_valid     = 1'b0;
  logic                     in_stall;
  logic [SAMPLE_W-1:0]      sample_value = '0;
  logic                     first_sample = 1'b0;
  logic                     out_valid;
  logic                     out_stall    = 1'b0;
  logic signed [DATA_W-1:0] deconvolved_value;
  logic [OUT_IDX_W-1:0]     sample_index;
  logic                     saturated;

  logic [COEF_W-1:0]        pulse_shape [WAVE_LENGTH];
  logic signed [DATA_W-1:0] prior_y [WAVE_LENGTH];
  int                       wave_pos   = 0;
  logic [PED_W-1:0]         pedestal_q = '0;

  decon_result_t pending_decon[$];
  stim_row_t     stim_rows[$];
  int            err_count   = 0;
  int            hold_asked  = 0;

  pulse_shape_deconvolver_core dut (
    .clk               (clk),
    .rst               (rst),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .sample_value      (sample_value),
    .first_sample      (first_sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .deconvolved_value (deconvolved_value),
    .sample_index      (sample_index),
    .saturated         (saturated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #40_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // pulse shape rom, q1.15, from a running exp(-k/8) in q31
  initial begin
    longint unsigned ex;
    longint unsigned term;
    ex = 64'd1 << 31;
    for (int k = 0; k < SHAPE_OFS + WAVE_LENGTH; k++) begin
      if (k >= SHAPE_OFS) begin
        term = 64'(k) * ex + (64'd1 << 18);
        pulse_shape[k - SHAPE_OFS] = COEF_W'(term >> 19);
      end
      ex = (ex * 64'd1895147668 + (64'd1 << 30)) >> 31;
    end
  end

  function automatic decon_result_t deconvolve_sample(input logic [SAMPLE_W-1:0] smp,
                                                      input logic first);
    decon_result_t r;
    int            pos;
    longint        acc;
    longint        y;
    pos = first ? 0 : wave_pos;
    acc = (longint'(smp) * 256 - longint'(pedestal_q) * 16) * 32768;
    for (int j = 0; j < pos; j++)
      acc -= longint'(pulse_shape[pos - j]) * longint'(prior_y[j]);
    if (acc > ACC_BOUND) acc = ACC_BOUND;
    if (acc < -ACC_BOUND) acc = -ACC_BOUND;
    y = (acc * E_SCALE + (64'sd1 <<< 30)) >>> 31;
    r.sat = 1'b0;
    if (y > Y_MAX) begin
      y = Y_MAX;
      r.sat = 1'b1;
    end else if (y < Y_MIN) begin
      y = Y_MIN;
      r.sat = 1'b1;
    end
    r.amp = y[DATA_W-1:0];
    r.idx = OUT_IDX_W'(pos);
    prior_y[pos] = y[DATA_W-1:0];
    wave_pos = (pos + 1 >= WAVE_LENGTH) ? 0 : pos + 1;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 5);
    if (r < 99) return $urandom_range(6, 60);
    return $urandom_range(61, 300);
  endfunction

  function automatic void add_write(input logic [ADDR_W-1:0] a, input logic [31:0] d);
    stim_row_t row;
    row       = '0;
    row.kind  = ROW_WRITE;
    row.addr  = a;
    row.wdata = d;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_sample(input logic [SAMPLE_W-1:0] smp, input logic first,
                                     input logic typed, input logic [DATA_W-1:0] amp);
    stim_row_t row;
    row          = '0;
    row.kind     = ROW_SAMPLE;
    row.smp      = smp;
    row.first    = first;
    row.typed    = typed;
    row.want.amp = amp;
    stim_rows.push_back(row);
  endfunction

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic apb_write(input logic [ADDR_W-1:0] a, input logic [31:0] d);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (a == ADDR_PEDESTAL) pedestal_q = d[PED_W-1:0];
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_decon.size() != 0) @(posedge clk);
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic first, input int gap,
                             input logic typed, input decon_result_t want);
    decon_result_t calc;
    sample_value <= smp;
    first_sample <= first;
    in_valid     <= 1'b1;
    do @(posedge clk); while (in_stall);
    calc = deconvolve_sample(smp, first);
    pending_decon.push_back(typed ? want : calc);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic check_result();
    decon_result_t want;
    if (pending_decon.size() == 0) begin
      flag_error($sformatf("unexpected result value %0d index %0d sat %0b",
                           deconvolved_value, sample_index, saturated));
    end else begin
      want = pending_decon.pop_front();
      if (deconvolved_value !== want.amp || sample_index !== want.idx ||
          saturated !== want.sat)
        flag_error($sformatf("expected value %0d index %0d sat %0b, got %0d %0d %0b",
                             $signed(want.amp), want.idx, want.sat,
                             deconvolved_value, sample_index, saturated));
    end
  endtask

  // result side: random stalls, long hold on request
  initial begin
    int stall_left;
    int free_left;
    int hold_seen;
    int r;
    stall_left = 0;
    free_left  = 0;
    hold_seen  = 0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) check_result();
      if (hold_seen != hold_asked) begin
        hold_seen  = hold_asked;
        stall_left = HOLD_CYCLES;
        free_left  = 0;
      end
      if (stall_left == 0 && free_left == 0) begin
        r = $urandom_range(0, 99);
        if (r < 5) free_left = $urandom_range(200, 600);
        else if (r < 70) free_left = $urandom_range(1, 30);
        else if (r < 93) stall_left = $urandom_range(1, 4);
        else if (r < 99) stall_left = $urandom_range(5, 40);
        else stall_left = $urandom_range(41, 200);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (free_left > 0) free_left--;
      end
    end
  end

  // request side
  initial begin
    stim_row_t         row;
    decon_result_t     none;
    logic [PED_W-1:0]  ped;
    logic [SAMPLE_W-1:0] smp;
    logic              first;
    int                sent;
    int                wave_len;
    int                r;
    int                base;
    int                gap;
    int                waited;

    none = '0;
    // after reset, pedestal zero
    add_sample(12'd0,    1'b1, 1'b1, 32'sd0);
    add_sample(12'd4095, 1'b1, 1'b1, 32'sd2849624);
    add_sample(12'd4095, 1'b0, 1'b0, '0);
    add_sample(12'd0,    1'b0, 1'b0, '0);
    add_sample(12'd2048, 1'b0, 1'b0, '0);
    add_sample(12'd1,    1'b0, 1'b0, '0);
    // restart in the middle of a waveform
    add_sample(12'd4095, 1'b1, 1'b1, 32'sd2849624);
    add_sample(12'd100,  1'b0, 1'b0, '0);
    // top pedestal, excess data bits ignored
    add_write(ADDR_PEDESTAL, 32'hFFFF_FFFF);
    add_sample(12'd0,    1'b1, 1'b1, -32'sd2850277);
    add_sample(12'd4095, 1'b0, 1'b0, '0);
    add_sample(12'd0,    1'b0, 1'b0, '0);
    add_sample(12'd4095, 1'b1, 1'b0, '0);
    // unmapped register leaves the pedestal alone
    add_write(ADDR_SPARE, 32'h0000_0000);
    add_sample(12'd0,    1'b1, 1'b1, -32'sd2850277);
    add_write(ADDR_PEDESTAL, 32'hABCD_1230);
    add_sample(12'd4095, 1'b1, 1'b0, '0);
    for (int i = 0; i < 10; i++)
      add_sample((i % 2 == 0) ? 12'd0 : 12'd4095, 1'b0, 1'b0, '0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      if (row.kind == ROW_WRITE) begin
        wait_drained();
        apb_write(row.addr, row.wdata);
      end else begin
        send_sample(row.smp, row.first, pick_gap(), row.typed, row.want);
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0:       ped = '0;
        1:       ped = '1;
        2:       ped = PED_W'(16 * $urandom_range(0, 300));
        default: ped = PED_W'($urandom_range(0, 65535));
      endcase
      wait_drained();
      if ($urandom_range(0, 2) == 0) apb_write(ADDR_SPARE, $urandom);
      apb_write(ADDR_PEDESTAL, {16'($urandom), ped});
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 10) wave_len = WAVE_LENGTH;
        else if (r < 20) wave_len = $urandom_range(WAVE_LENGTH + 1, 2 * WAVE_LENGTH + 20);
        else if (r < 30) wave_len = $urandom_range(1, 3);
        else wave_len = $urandom_range(4, WAVE_LENGTH - 1);
        for (int n = 0; n < wave_len && sent < PHASE_ITEMS; n++) begin
          first = (n == 0) || ($urandom_range(0, 99) < 2);
          r = $urandom_range(0, 99);
          if (r < 10) begin
            smp = '0;
          end else if (r < 20) begin
            smp = '1;
          end else if (r < 35) begin
            base = int'(ped >> 4) + $urandom_range(0, 8) - 4;
            if (base < 0) base = 0;
            if (base > 4095) base = 4095;
            smp = SAMPLE_W'(base);
          end else begin
            smp = SAMPLE_W'($urandom_range(0, 4095));
          end
          if (ph == 2 && sent == 20) hold_asked++;
          if (ph == 3 || (ph == 2 && sent >= 20 && sent < 40)) gap = 0;
          else gap = pick_gap();
          send_sample(smp, first, gap, 1'b0, none);
          sent++;
        end
      end
    end

    in_valid <= 1'b0;
    waited = 0;
    while (pending_decon.size() != 0 && waited < 200_000) begin
      @(posedge clk);
      waited++;
    end
    repeat (2 * LATENCY) @(posedge clk);
    if (pending_decon.size() != 0)
      flag_error($sformatf("%0d results never arrived", pending_decon.size()));
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/psdc_pkg.sv
rtl/core/psdc_cell.sv
rtl/core/psdc_mac.sv
rtl/core/psdc_scale.sv
rtl/core/pulse_shape_deconvolver_core.sv
dv/tb.sv
